/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
// both expect signals named clk and rst in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define QTE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qte check failed");

// next-cycle implication, held off during reset
`define QTE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qte check failed");

`endif

/* hw/rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, CORDIC angle table and item types for the quaternion to
// Euler angle (YXZ) pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int NORM_WIDTH      = 16;
  localparam int PROD_WIDTH      = 2 * NORM_WIDTH;
  localparam int TERM_WIDTH      = 34;
  localparam int SINE_FRAC       = 30;
  localparam int QUOT_WIDTH      = SINE_FRAC + 1;
  localparam int SQ_WIDTH        = 2 * QUOT_WIDTH;
  localparam int RAD_WIDTH       = 2 * SINE_FRAC + 1;
  localparam int ROOT_WIDTH      = SINE_FRAC + 1;
  localparam int SINE_WIDTH      = SINE_FRAC + 2;
  localparam int THRESH_WIDTH    = 21;
  localparam int CORDIC_STEPS    = 30;
  localparam int CORDIC_WIDTH    = 44;
  localparam int CORDIC_TOP      = 40;
  localparam int ANGLE_WIDTH     = 34;
  localparam int CORDIC_LATENCY  = CORDIC_STEPS + 3;
  localparam int Q13_WIDTH       = 18;
  localparam int Q13_SHIFT       = SINE_FRAC - 13;
  localparam int PITCH_LIMIT     = 12868;
  localparam int ANGLE_LIMIT     = 25736;

  localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANGLE_WIDTH-1:0] Q13_ROUND   = 34'sd65536;

  // atan(2^-i) in units of 2^-30, rounded down
  localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1
  };

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] quat_x;
    logic signed [COMPONENT_WIDTH-1:0] quat_y;
    logic signed [COMPONENT_WIDTH-1:0] quat_z;
    logic signed [COMPONENT_WIDTH-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               gimbal_locked;
    logic               invalid_input;
  } euler_t;

  // rotation terms, all numerators over the squared norm n
  typedef struct packed {
    logic [31:0]                   n;
    logic [31:0]                   ap;
    logic                          ps_neg;
    logic                          invalid;
    logic signed [TERM_WIDTH-1:0]  yl_num;
    logic signed [TERM_WIDTH-1:0]  yl_den;
    logic signed [TERM_WIDTH-1:0]  yaw_num;
    logic signed [TERM_WIDTH-1:0]  yaw_den;
    logic signed [TERM_WIDTH-1:0]  roll_num;
    logic signed [TERM_WIDTH-1:0]  roll_den;
  } terms_t;

  typedef struct packed {
    logic signed [SINE_WIDTH-1:0]  sine;
    logic                          locked;
    logic                          invalid;
    logic signed [TERM_WIDTH-1:0]  yaw_num;
    logic signed [TERM_WIDTH-1:0]  yaw_den;
    logic signed [TERM_WIDTH-1:0]  roll_num;
    logic signed [TERM_WIDTH-1:0]  roll_den;
  } root_side_t;

endpackage

/* hw/rtl/qte_prep.sv */
// ----------------------------------------------------------------------------
// qte_prep
// Scales the quaternion to a common magnitude and forms the squared norm,
// pitch sine numerator and yaw/roll atan2 operands in four stages.
// ----------------------------------------------------------------------------
module qte_prep import qte_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  quat_t  quat,
  output logic   out_valid,
  output terms_t terms
);

  localparam int MW    = COMPONENT_WIDTH;
  localparam int MSB_W = $clog2(MW);
  localparam int SW    = MW + NORM_WIDTH - 2;

  // stage 1: magnitudes and common leading one
  logic signed [MW-1:0] comp_c [4];
  logic [MW-1:0]        mag_c [4];
  logic [MW-1:0]        any_c;
  logic [MSB_W-1:0]     msb_c;

  logic [MW-1:0]    mag1 [4];
  logic [3:0]       neg1;
  logic [MSB_W-1:0] msb1;
  logic             inv1;
  logic             vld1;

  always_comb begin
    comp_c[0] = quat.quat_x;
    comp_c[1] = quat.quat_y;
    comp_c[2] = quat.quat_z;
    comp_c[3] = quat.quat_w;
    any_c = '0;
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = comp_c[i][MW-1] ? MW'(-comp_c[i]) : MW'(comp_c[i]);
      any_c = any_c | mag_c[i];
    end
    msb_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (any_c[i]) msb_c = MSB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= comp_c[i][MW-1];
      end
      msb1 <= msb_c;
      inv1 <= (any_c == '0);
    end
  end

  // stage 2: shift so the largest magnitude has its top bit at 2^14
  logic [SW-1:0]                wide_c [4];
  logic signed [NORM_WIDTH-1:0] norm_c [4];
  logic signed [NORM_WIDTH-1:0] q2 [4];
  logic                         inv2;
  logic                         vld2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide_c[i] = {mag1[i], {(NORM_WIDTH-2){1'b0}}} >> msb1;
      norm_c[i] = $signed({1'b0, wide_c[i][NORM_WIDTH-2:0]});
      if (neg1[i]) norm_c[i] = -norm_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) q2[i] <= norm_c[i];
      inv2 <= inv1;
    end
  end

  // stage 3: products
  logic signed [PROD_WIDTH-1:0] xx, yy, zz, ww, xw, yz, xz, yw, xy, zw;
  logic inv3;
  logic vld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx   <= q2[0] * q2[0];
      yy   <= q2[1] * q2[1];
      zz   <= q2[2] * q2[2];
      ww   <= q2[3] * q2[3];
      xw   <= q2[0] * q2[3];
      yz   <= q2[1] * q2[2];
      xz   <= q2[0] * q2[2];
      yw   <= q2[1] * q2[3];
      xy   <= q2[0] * q2[1];
      zw   <= q2[2] * q2[3];
      inv3 <= inv2;
    end
  end

  // stage 4: sums
  logic signed [TERM_WIDTH-1:0] exx, eyy, ezz, eww, exw, eyz, exz, eyw, exy, ezw;
  logic signed [TERM_WIDTH-1:0] n_c, ps_c;

  always_comb begin
    exx  = TERM_WIDTH'(xx);
    eyy  = TERM_WIDTH'(yy);
    ezz  = TERM_WIDTH'(zz);
    eww  = TERM_WIDTH'(ww);
    exw  = TERM_WIDTH'(xw);
    eyz  = TERM_WIDTH'(yz);
    exz  = TERM_WIDTH'(xz);
    eyw  = TERM_WIDTH'(yw);
    exy  = TERM_WIDTH'(xy);
    ezw  = TERM_WIDTH'(zw);
    n_c  = exx + eyy + ezz + eww;
    ps_c = (exw - eyz) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms.n        <= n_c[31:0];
      terms.ap       <= ps_c[TERM_WIDTH-1] ? 32'(-ps_c) : ps_c[31:0];
      terms.ps_neg   <= ps_c[TERM_WIDTH-1];
      terms.invalid  <= inv3;
      terms.yl_num   <= (eyw - exz) <<< 1;
      terms.yl_den   <= exx + eww - eyy - ezz;
      terms.yaw_num  <= (exz + eyw) <<< 1;
      terms.yaw_den  <= ezz + eww - exx - eyy;
      terms.roll_num <= (exy + ezw) <<< 1;
      terms.roll_den <= eyy + eww - exx - ezz;
    end
  end

endmodule

/* hw/rtl/qte_div.sv */
// ----------------------------------------------------------------------------
// qte_div
// Pipelined restoring divider: |sine numerator| * 2^30 / n, one quotient bit
// per stage, with the rotation terms carried alongside.
// ----------------------------------------------------------------------------
module qte_div import qte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  terms_t                in_terms,
  output logic                  out_valid,
  output logic [QUOT_WIDTH-1:0] quot,
  output terms_t                out_terms
);

  localparam int RW = TERM_WIDTH;

  logic [RW-1:0]         rem  [QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] qv   [QUOT_WIDTH];
  terms_t                side [QUOT_WIDTH];
  logic                  vld  [QUOT_WIDTH];

  for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_stage
    logic [RW-1:0]         rem_in, diff;
    logic [QUOT_WIDTH-1:0] q_in, q_next;
    terms_t                side_in;
    logic                  vld_in, ge;

    if (i == 0) begin : g_first
      assign rem_in  = RW'(in_terms.ap);
      assign q_in    = '0;
      assign side_in = in_terms;
      assign vld_in  = in_valid;
    end else begin : g_rest
      assign rem_in  = rem[i-1];
      assign q_in    = qv[i-1];
      assign side_in = side[i-1];
      assign vld_in  = vld[i-1];
    end

    always_comb begin
      ge     = rem_in >= RW'(side_in.n);
      diff   = ge ? rem_in - RW'(side_in.n) : rem_in;
      q_next = q_in;
      q_next[QUOT_WIDTH-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= diff << 1;
        qv[i]   <= q_next;
        side[i] <= side_in;
      end
    end
  end

  assign out_valid = vld[QUOT_WIDTH-1];
  assign quot      = qv[QUOT_WIDTH-1];
  assign out_terms = side[QUOT_WIDTH-1];

endmodule

/* hw/rtl/qte_sqrt.sv */
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined integer square root (rounded down), one result bit per stage,
// giving the pitch cosine from 2^60 - sine^2.
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_WIDTH-1:0]  rad,
  input  root_side_t            in_side,
  output logic                  out_valid,
  output logic [ROOT_WIDTH-1:0] root,
  output root_side_t            out_side
);

  localparam int WW = RAD_WIDTH + 1;

  logic [RAD_WIDTH-1:0] vr   [ROOT_WIDTH];
  logic [WW-1:0]        rr   [ROOT_WIDTH];
  root_side_t           side [ROOT_WIDTH];
  logic                 vld  [ROOT_WIDTH];

  for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_stage
    localparam logic [WW-1:0] BIT = WW'(1) << (RAD_WIDTH - 1 - 2 * j);

    logic [RAD_WIDTH-1:0] v_in, v_next;
    logic [WW-1:0]        r_in, r_next, trial;
    root_side_t           side_in;
    logic                 vld_in, ge;

    if (j == 0) begin : g_first
      assign v_in    = rad;
      assign r_in    = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_rest
      assign v_in    = vr[j-1];
      assign r_in    = rr[j-1];
      assign side_in = side[j-1];
      assign vld_in  = vld[j-1];
    end

    always_comb begin
      trial  = r_in + BIT;
      ge     = {1'b0, v_in} >= trial;
      v_next = ge ? v_in - trial[RAD_WIDTH-1:0] : v_in;
      r_next = ge ? (r_in >> 1) + BIT : r_in >> 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vr[j]   <= v_next;
        rr[j]   <= r_next;
        side[j] <= side_in;
      end
    end
  end

  assign out_valid = vld[ROOT_WIDTH-1];
  assign root      = rr[ROOT_WIDTH-1][ROOT_WIDTH-1:0];
  assign out_side  = side[ROOT_WIDTH-1];

endmodule

/* hw/rtl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2(y, x): quarter-turn pre-rotation, operand
// scaling into [2^40, 2^41), then one micro-rotation per stage. Q30 radians.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [TERM_WIDTH-1:0]  ya,
  input  logic signed [TERM_WIDTH-1:0]  xa,
  output logic                          out_valid,
  output logic signed [ANGLE_WIDTH-1:0] angle
);

  localparam int PW    = TERM_WIDTH + 1;
  localparam int SH_W  = $clog2(CORDIC_TOP + 1);
  localparam int MSB_W = $clog2(PW);

  // pre-rotation so that x is zero or above
  logic signed [PW-1:0]          xe_c, ye_c, px_c, py_c;
  logic signed [ANGLE_WIDTH-1:0] pacc_c;

  logic signed [PW-1:0]          p_x, p_y;
  logic signed [ANGLE_WIDTH-1:0] p_acc;
  logic                          p_zero, p_vld;

  always_comb begin
    xe_c   = PW'(xa);
    ye_c   = PW'(ya);
    px_c   = xe_c;
    py_c   = ye_c;
    pacc_c = '0;
    if (xe_c < 0) begin
      if (ye_c >= 0) begin
        px_c   = ye_c;
        py_c   = -xe_c;
        pacc_c = HALF_PI_Q30;
      end else begin
        px_c   = -ye_c;
        py_c   = xe_c;
        pacc_c = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x    <= px_c;
      p_y    <= py_c;
      p_acc  <= pacc_c;
      p_zero <= (xa == '0) && (ya == '0);
    end
  end

  // find the scaling shift from the larger magnitude
  logic [PW-1:0]    my_c, big_c;
  logic [MSB_W-1:0] msb_c;

  logic signed [PW-1:0]          k_x, k_y;
  logic signed [ANGLE_WIDTH-1:0] k_acc;
  logic [SH_W-1:0]               k_sh;
  logic                          k_zero, k_vld;

  always_comb begin
    my_c  = p_y[PW-1] ? PW'(-p_y) : PW'(p_y);
    big_c = (PW'(p_x) > my_c) ? PW'(p_x) : my_c;
    msb_c = '0;
    for (int i = 0; i < PW; i++) begin
      if (big_c[i]) msb_c = MSB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (en) begin
      k_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_x    <= p_x;
      k_y    <= p_y;
      k_acc  <= p_acc;
      k_sh   <= SH_W'(CORDIC_TOP) - SH_W'(msb_c);
      k_zero <= p_zero;
    end
  end

  // micro-rotation pipeline, index 0 holds the scaled operands
  logic signed [CORDIC_WIDTH-1:0] cx   [CORDIC_STEPS+1];
  logic signed [CORDIC_WIDTH-1:0] cy   [CORDIC_STEPS+1];
  logic signed [ANGLE_WIDTH-1:0]  cacc [CORDIC_STEPS+1];
  logic                           czer [CORDIC_STEPS+1];
  logic                           cvld [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else if (en) begin
      cvld[0] <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= CORDIC_WIDTH'(k_x) <<< k_sh;
      cy[0]   <= CORDIC_WIDTH'(k_y) <<< k_sh;
      cacc[0] <= k_acc;
      czer[0] <= k_zero;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANGLE_WIDTH-1:0] STEP = ANGLE_WIDTH'(ATAN_TABLE[i]);

    logic signed [CORDIC_WIDTH-1:0] dx, dy;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else if (en) begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CORDIC_WIDTH-1]) begin
          cx[i+1]   <= cx[i] + dx;
          cy[i+1]   <= cy[i] - dy;
          cacc[i+1] <= cacc[i] + STEP;
        end else begin
          cx[i+1]   <= cx[i] - dx;
          cy[i+1]   <= cy[i] + dy;
          cacc[i+1] <= cacc[i] - STEP;
        end
        czer[i+1] <= czer[i];
      end
    end
  end

  assign out_valid = cvld[CORDIC_STEPS];
  assign angle     = czer[CORDIC_STEPS] ? '0 : cacc[CORDIC_STEPS];

endmodule

/* hw/rtl/quaternion_to_euler_yxz.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_yxz
// Quaternion (x, y, z, w) to Euler angles for R = Ry(yaw) Rx(pitch) Rz(roll),
// Q13 radians, with gimbal lock detection and an all-zero input flag.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while the output is not stalled. Each
// result passes through scaling and products, the bit-per-stage sine divider,
// sine squared, the bit-per-stage cosine square root, the three parallel CORDIC
// atan2 pipelines and an output register. A stall on the output holds the
// whole pipeline in place and raises quat_stall in the same cycle.
// gimbal_threshold resets to 1 and is loaded by threshold_we; it takes effect
// on items computed after the write.
module quaternion_to_euler_yxz import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    quat_valid,
  output logic                    quat_stall,
  input  quat_t                   quat,
  output logic                    euler_valid,
  input  logic                    euler_stall,
  output euler_t                  euler,
  input  logic                    threshold_we,
  input  logic [THRESH_WIDTH-1:0] threshold_data
);

  localparam logic [QUOT_WIDTH-1:0] SINE_ONE = QUOT_WIDTH'(1) << SINE_FRAC;
  localparam logic [SQ_WIDTH-1:0]   SQ_ONE   = SQ_WIDTH'(1) << (2 * SINE_FRAC);

  logic en;
  logic [THRESH_WIDTH-1:0] gimbal_threshold;

  assign en         = !(euler_valid && euler_stall);
  assign quat_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_threshold <= THRESH_WIDTH'(1);
    end else if (threshold_we) begin
      gimbal_threshold <= threshold_data;
    end
  end

  // scaling and rotation terms
  logic   prep_vld;
  terms_t prep_terms;

  qte_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat_valid),
    .quat      (quat),
    .out_valid (prep_vld),
    .terms     (prep_terms)
  );

  // pitch sine magnitude
  logic                  div_vld;
  logic [QUOT_WIDTH-1:0] div_quot;
  terms_t                div_terms;

  qte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_vld),
    .in_terms  (prep_terms),
    .out_valid (div_vld),
    .quot      (div_quot),
    .out_terms (div_terms)
  );

  // sine clamp, gimbal test, yaw operand choice, sine squared and the cosine radicand
  logic [QUOT_WIDTH-1:0]   smag_c;
  logic                    locked_c;
  logic [SQ_WIDTH-1:0]     a_sq;
  root_side_t              a_side;
  logic                    a_vld;
  logic [RAD_WIDTH-1:0]    b_rad;
  root_side_t              b_side;
  logic                    b_vld;

  always_comb begin
    smag_c   = (div_quot > SINE_ONE) ? SINE_ONE : div_quot;
    locked_c = (SINE_ONE - smag_c) < QUOT_WIDTH'(gimbal_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= div_vld;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sq           <= SQ_WIDTH'(smag_c) * SQ_WIDTH'(smag_c);
      a_side.sine    <= div_terms.ps_neg ? -$signed(SINE_WIDTH'(smag_c))
                                         : $signed(SINE_WIDTH'(smag_c));
      a_side.locked  <= locked_c;
      a_side.invalid <= div_terms.invalid;
      a_side.yaw_num <= locked_c ? div_terms.yl_num : div_terms.yaw_num;
      a_side.yaw_den <= locked_c ? div_terms.yl_den : div_terms.yaw_den;
      a_side.roll_num <= div_terms.roll_num;
      a_side.roll_den <= div_terms.roll_den;
      b_rad          <= RAD_WIDTH'(SQ_ONE - a_sq);
      b_side         <= a_side;
    end
  end

  // pitch cosine
  logic                  root_vld;
  logic [ROOT_WIDTH-1:0] root;
  root_side_t            r_side;

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_vld),
    .rad       (b_rad),
    .in_side   (b_side),
    .out_valid (root_vld),
    .root      (root),
    .out_side  (r_side)
  );

  // three atan2 pipelines
  logic                          pitch_vld, yaw_vld, roll_vld;
  logic signed [ANGLE_WIDTH-1:0] pitch_q30, yaw_q30, roll_q30;

  qte_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_vld),
    .ya        (TERM_WIDTH'(r_side.sine)),
    .xa        ($signed(TERM_WIDTH'(root))),
    .out_valid (pitch_vld),
    .angle     (pitch_q30)
  );

  qte_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_vld),
    .ya        (r_side.yaw_num),
    .xa        (r_side.yaw_den),
    .out_valid (yaw_vld),
    .angle     (yaw_q30)
  );

  qte_cordic u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_vld),
    .ya        (r_side.roll_num),
    .xa        (r_side.roll_den),
    .out_valid (roll_vld),
    .angle     (roll_q30)
  );

  // flags ride alongside the CORDIC pipelines
  logic lock_d [CORDIC_LATENCY];
  logic inv_d  [CORDIC_LATENCY];

  for (genvar i = 0; i < CORDIC_LATENCY; i++) begin : g_flag
    logic lock_in, inv_in;
    if (i == 0) begin : g_first
      assign lock_in = r_side.locked;
      assign inv_in  = r_side.invalid;
    end else begin : g_rest
      assign lock_in = lock_d[i-1];
      assign inv_in  = inv_d[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lock_d[i] <= lock_in;
        inv_d[i]  <= inv_in;
      end
    end
  end

  // round Q30 to Q13 and clamp
  function automatic logic signed [Q13_WIDTH-1:0] to_q13(
    input logic signed [ANGLE_WIDTH-1:0] a,
    input logic signed [Q13_WIDTH-1:0]   lim
  );
    logic signed [ANGLE_WIDTH:0]   t;
    logic signed [Q13_WIDTH-1:0]   r;
    t = (ANGLE_WIDTH+1)'(a) + (ANGLE_WIDTH+1)'(Q13_ROUND);
    r = Q13_WIDTH'(t >>> Q13_SHIFT);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [Q13_WIDTH-1:0] pitch_c, yaw_c, roll_c;
  logic                        lock_o, inv_o;

  always_comb begin
    lock_o  = lock_d[CORDIC_LATENCY-1];
    inv_o   = inv_d[CORDIC_LATENCY-1];
    pitch_c = to_q13(pitch_q30, Q13_WIDTH'(PITCH_LIMIT));
    yaw_c   = to_q13(yaw_q30, Q13_WIDTH'(ANGLE_LIMIT));
    roll_c  = to_q13(roll_q30, Q13_WIDTH'(ANGLE_LIMIT));
    if (lock_o || inv_o) roll_c = '0;
    if (inv_o) begin
      pitch_c = '0;
      yaw_c   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      euler_valid <= 1'b0;
    end else if (en) begin
      euler_valid <= pitch_vld && yaw_vld && roll_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      euler.pitch_angle   <= pitch_c[14:0];
      euler.yaw_angle     <= yaw_c[15:0];
      euler.roll_angle    <= roll_c[15:0];
      euler.gimbal_locked <= lock_o && !inv_o;
      euler.invalid_input <= inv_o;
    end
  end

endmodule

/* hw/rtl/qte_checker.sv */
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the result channel of quaternion_to_euler_yxz and its
// stall coupling to the input side, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qte_checker import qte_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   quat_stall,
  input logic   euler_valid,
  input logic   euler_stall,
  input euler_t euler
);

  logic angles_zero;
  logic pitch_in_range;

  assign angles_zero    = euler.pitch_angle == 0 && euler.yaw_angle == 0 &&
                          euler.roll_angle == 0;
  assign pitch_in_range = euler.pitch_angle <= PITCH_LIMIT &&
                          euler.pitch_angle >= -PITCH_LIMIT;

  // a stalled item stays put
  `QTE_ASSERT_NXT(a_hold, euler_valid && euler_stall, euler_valid && $stable(euler))

  // a stalled output holds the input side too
  `QTE_ASSERT_IMP(a_backpressure, euler_valid && euler_stall, quat_stall)

  // all-zero quaternion gives zero angles and no lock
  `QTE_ASSERT_IMP(a_invalid_zero, euler_valid && euler.invalid_input, angles_zero && !euler.gimbal_locked)

  `QTE_ASSERT_IMP(a_lock_roll, euler_valid && euler.gimbal_locked, euler.roll_angle == 0)

  `QTE_ASSERT_IMP(a_pitch_range, euler_valid, pitch_in_range)

endmodule

bind quaternion_to_euler_yxz qte_checker u_qte_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_to_euler_yxz: directed and random
// quaternions are predicted in SystemVerilog, each result item is compared
// field by field with the oldest prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import qte_pkg::*;

  localparam int DRAIN_CYCLES = 130;

  logic                    clk;
  logic                    rst;
  logic                    quat_valid;
  logic                    quat_stall;
  quat_t                   quat;
  logic                    euler_valid;
  logic                    euler_stall;
  euler_t                  euler;
  logic                    threshold_we;
  logic [THRESH_WIDTH-1:0] threshold_data;

  quaternion_to_euler_yxz dut (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .euler_valid(euler_valid), .euler_stall(euler_stall), .euler(euler),
    .threshold_we(threshold_we), .threshold_data(threshold_data)
  );

  // own copy of the atan(2^-i) table in units of 2^-30
  localparam longint ATAN_Q30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1};

  euler_t             euler_expected[$];
  logic [20:0]        thr_shadow;
  int                 errors;
  int                 items_sent;
  int                 results_seen;
  int                 locked_seen;
  bit                 tx_gaps;
  bit                 rx_gaps;
  int                 hold_cycles;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint atan2_q30(longint ya, longint xa);
    longint acc, t, dx, dy;
    longint unsigned my, big;
    int k;
    acc = 0;
    k = 0;
    if (xa == 0 && ya == 0) return 0;
    // quarter turn so that x is not negative
    if (xa < 0) begin
      t = xa;
      if (ya >= 0) begin
        xa = ya; ya = -t; acc = 1686629713;
      end else begin
        xa = -ya; ya = t; acc = -1686629713;
      end
    end
    my = longint'(ya < 0 ? -ya : ya);
    big = (longint'(xa) > longint'(my)) ? xa : my;
    while (big < (64'd1 << 40)) begin
      big = big << 1;
      k++;
    end
    xa = xa <<< k;
    ya = ya <<< k;
    for (int i = 0; i < 30; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya >= 0) begin
        xa += dx; ya -= dy; acc += ATAN_Q30[i];
      end else begin
        xa -= dx; ya += dy; acc -= ATAN_Q30[i];
      end
    end
    return acc;
  endfunction

  function automatic longint q30_to_q13(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic euler_t predict_euler(quat_t q, logic [20:0] thr);
    euler_t e;
    longint comp[4];
    longint unsigned mag[4];
    longint unsigned m, ap, smag, cosv;
    longint x, y, z, w, n, ps, s, pitch, yaw, roll;
    int rs, ls;
    bit locked;
    comp[0] = q.quat_x; comp[1] = q.quat_y; comp[2] = q.quat_z; comp[3] = q.quat_w;
    m = 0; rs = 0; ls = 0;
    e = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      e.invalid_input = 1'b1;
      return e;
    end
    while (m >= 32768) begin m = m >> 1; rs++; end
    while (m < 16384) begin m = m << 1; ls++; end
    for (int i = 0; i < 4; i++)
      comp[i] = comp[i] < 0 ? -longint'((mag[i] >> rs) << ls) : longint'((mag[i] >> rs) << ls);
    x = comp[0]; y = comp[1]; z = comp[2]; w = comp[3];
    n = x*x + y*y + z*z + w*w;
    ps = 2 * (x*w - y*z);
    ap = ps < 0 ? -ps : ps;
    smag = (ap << 30) / longint'(n);
    if (smag > (64'd1 << 30)) smag = 64'd1 << 30;
    s = ps < 0 ? -longint'(smag) : longint'(smag);
    cosv = isqrt_floor((64'd1 << 60) - smag * smag);
    pitch = atan2_q30(s, longint'(cosv));
    locked = ((64'd1 << 30) - smag) < longint'(thr);
    if (locked) begin
      yaw = atan2_q30(2 * (y*w - x*z), n - 2 * (y*y + z*z));
      roll = 0;
    end else begin
      yaw = atan2_q30(2 * (x*z + y*w), n - 2 * (x*x + y*y));
      roll = atan2_q30(2 * (x*y + z*w), n - 2 * (x*x + z*z));
    end
    e.pitch_angle = 15'(q30_to_q13(pitch, 12868));
    e.yaw_angle = 16'(q30_to_q13(yaw, 25736));
    e.roll_angle = 16'(q30_to_q13(roll, 25736));
    e.gimbal_locked = locked;
    return e;
  endfunction

  // record a prediction for every accepted item
  always @(posedge clk) begin
    if (!rst && quat_valid && !quat_stall) begin
      euler_expected.push_back(predict_euler(quat, thr_shadow));
      items_sent++;
    end
  end

  // result checker
  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst && euler_valid && !euler_stall) begin
      results_seen++;
      if (euler.gimbal_locked) locked_seen++;
      if (euler_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, actual %h", $time, euler);
      end else begin
        exp_e = euler_expected.pop_front();
        if (euler.pitch_angle !== exp_e.pitch_angle) begin
          errors++;
          $display("%0t: pitch expected %0d actual %0d", $time,
                   exp_e.pitch_angle, euler.pitch_angle);
        end
        if (euler.yaw_angle !== exp_e.yaw_angle) begin
          errors++;
          $display("%0t: yaw expected %0d actual %0d", $time,
                   exp_e.yaw_angle, euler.yaw_angle);
        end
        if (euler.roll_angle !== exp_e.roll_angle) begin
          errors++;
          $display("%0t: roll expected %0d actual %0d", $time,
                   exp_e.roll_angle, euler.roll_angle);
        end
        if (euler.gimbal_locked !== exp_e.gimbal_locked) begin
          errors++;
          $display("%0t: gimbal_locked expected %b actual %b", $time,
                   exp_e.gimbal_locked, euler.gimbal_locked);
        end
        if (euler.invalid_input !== exp_e.invalid_input) begin
          errors++;
          $display("%0t: invalid_input expected %b actual %b", $time,
                   exp_e.invalid_input, euler.invalid_input);
        end
      end
    end
  end

  // receiver: random stall per item, plus long hold-offs on request
  initial begin
    int stall_left;
    bit stall_now;
    stall_left = 0;
    euler_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (euler_valid && !euler_stall)
        stall_left = rx_gaps ? $urandom_range(0, 18) : 0;
      if (hold_cycles > 0) begin
        hold_cycles--;
        stall_now = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      euler_stall <= stall_now;
    end
  end

  task automatic send_quat(input quat_t q);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      quat_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat_valid <= 1'b1;
    quat <= q;
    @(negedge clk);
    while (quat_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic stop_sending();
    quat_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (euler_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [20:0] v);
    stop_sending();
    wait_drained();
    threshold_we <= 1'b1;
    threshold_data <= v;
    @(posedge clk);
    threshold_we <= 1'b0;
    thr_shadow = v;
  endtask

  function automatic quat_t mk_quat(int x, int y, int z, int w);
    quat_t q;
    q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z); q.quat_w = 16'(w);
    return q;
  endfunction

  // quaternion close to pitch of plus or minus a quarter turn
  function automatic quat_t near_lock_quat();
    int a, e, d;
    a = $urandom_range(200, 32767);
    e = $urandom_range(0, a / 64 + 1);
    d = $urandom_range(0, a / 256 + 1);
    if ($urandom_range(0, 1)) a = -a;
    return mk_quat(a, ($urandom_range(0, 1) ? e : -e), ($urandom_range(0, 1) ? e : -e),
                   ($urandom_range(0, 1) ? a + d : -a - d));
  endfunction

  function automatic quat_t random_quat();
    int sel;
    quat_t q;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      q = quat_t'({$urandom, $urandom});
    end else if (sel < 80) begin
      q = near_lock_quat();
    end else if (sel < 93) begin
      q = mk_quat($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                  $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
    end else if (sel < 97) begin
      q = quat_t'({$urandom, $urandom});
      if ($urandom_range(0, 1)) q.quat_x = 16'sh8000;
      if ($urandom_range(0, 1)) q.quat_w = 16'sh8000;
    end else begin
      q = '0;
    end
    return q;
  endfunction

  task automatic test_directed();
    quat_t dq[$];
    dq = '{mk_quat(0, 0, 0, 0), mk_quat(0, 0, 0, 32767), mk_quat(0, 0, 0, -32768),
           mk_quat(-32768, -32768, -32768, -32768), mk_quat(32767, 32767, 32767, 32767),
           mk_quat(-32768, 32767, -32768, 32767), mk_quat(1, 0, 0, 0),
           mk_quat(0, 0, 0, -1), mk_quat(-32768, 0, 0, 0), mk_quat(0, 1, 0, 0),
           mk_quat(0, 0, 1, 0), mk_quat(1, 1, 1, 1), mk_quat(20000, 0, 0, 20000),
           mk_quat(20000, 0, 0, -20000), mk_quat(-32768, 0, 0, -32768),
           mk_quat(1000, 5, -5, 1000), mk_quat(0, 0, 32767, 0),
           mk_quat(0, -32768, 0, 0), mk_quat(12345, -23456, 3456, -7),
           mk_quat(0, 1, 0, -1)};
    foreach (dq[i]) send_quat(dq[i]);
  endtask

  task automatic test_thresholds();
    logic [20:0] settings[5];
    settings = '{21'd0, 21'd1048576, 21'h1FFFFF, 21'd4096, 21'd1};
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      tx_gaps = (s % 2) == 0;
      for (int i = 0; i < 40; i++)
        send_quat((i % 2) ? near_lock_quat() : random_quat());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    tx_gaps = 1'b0;
    for (int i = 0; i < 200; i++) send_quat(random_quat());
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_gaps = $urandom_range(0, 2) != 0;
      end
      if (i == 600) begin
        write_threshold(21'($urandom_range(0, 1048576)));
      end
      send_quat(random_quat());
    end
    stop_sending();
  endtask

  initial begin
    errors = 0; items_sent = 0; results_seen = 0; locked_seen = 0;
    tx_gaps = 1'b1; rx_gaps = 1'b1; hold_cycles = 0;
    thr_shadow = 21'd1;
    rst <= 1'b1;
    quat_valid <= 1'b0;
    quat <= '0;
    threshold_we <= 1'b0;
    threshold_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    wait_drained();
    $display("covered %0d items and %0d results, %0d of them gimbal locked,",
             items_sent, results_seen, locked_seen);
    $display("over five threshold settings, random idling and a long output hold-off");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d items outstanding", euler_expected.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
